FILE: sv/imhcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_pkg: shared types and constants of the MH chain step core
// Beat formats of both channels, the queue tag, and the fixed-point
// constants of the exponent unit.
// ----------------------------------------------------------------------------
package imhcs_pkg;

    // One input beat: a candidate coordinate with its acceptance inputs.
    typedef struct packed {
        logic signed [31:0] coord_value;
        logic signed [31:0] log_weight;
        logic [16:0]        uniform;
        logic               new_chain;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic signed [31:0] draw_value;
        logic               accepted;
        logic               last_coord;
    } out_item_t;

    // Position flags that the front end attaches to each queued beat.
    typedef struct packed {
        logic first;
        logic last;
    } tag_t;

    localparam int DIM_CFG_W = 5;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 5'd1;

    localparam int QUEUE_DEPTH = 2;

    // Exponent unit constants.
    localparam logic [3:0]  EXP_TERMS    = 4'd12;
    localparam logic [31:0] EXP_NEG1_Q32 = 32'd1580030169;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam int          DIV_W        = 40;
    localparam int          DIV_BITS     = 8;
    localparam logic [2:0]  DIV_STEPS    = 3'd5;

endpackage

FILE: sv/imhcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_ram: generic single-port RAM
// One read or write per cycle at one address, registered read data.
// ----------------------------------------------------------------------------
module imhcs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [DATA_W-1:0]                      wdata,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/imhcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_queue: short FIFO between front end and back end
// Register-based queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module imhcs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              in_ready,
    input  logic [DATA_W-1:0] wdata,
    input  logic              pop,
    output logic              out_valid,
    output logic [DATA_W-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign rdata     = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/imhcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_front: input front end
// Accepts input beats, tracks the coordinate position and tags each beat
// as the first and/or last coordinate of its vector before queuing it.
// ----------------------------------------------------------------------------
module imhcs_front
    import imhcs_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  in_item_t                                   s_payload,
    input  logic [DIM_CFG_W-1:0]                       dim_cfg,
    output logic                                       q_push,
    input  logic                                       q_in_ready,
    output in_item_t                                   q_item,
    output tag_t                                       q_tag,
    output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] q_idx
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] dim_eff;
    logic             last;

    // A dimension of zero acts as one; anything above MAX_DIM acts as MAX_DIM.
    always_comb begin
        if (dim_cfg == '0) begin
            dim_eff = CNT_W'(1);
        end else if (32'(dim_cfg) > 32'(MAX_DIM)) begin
            dim_eff = CNT_W'(MAX_DIM);
        end else begin
            dim_eff = CNT_W'(dim_cfg);
        end
    end

    assign last       = (CNT_W'(idx_reg) + CNT_W'(1)) >= dim_eff;
    assign s_ready    = q_in_ready;
    assign q_push     = s_valid && q_in_ready;
    assign q_item     = s_payload;
    assign q_tag      = '{first: (idx_reg == '0), last: last};
    assign q_idx      = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (q_push) begin
            idx_reg <= last ? '0 : idx_reg + IDX_W'(1);
        end
    end

endmodule

FILE: sv/imhcs_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_exp: iterative exp() unit
// Computes exp(d) in Q1.16 for a signed Q16 difference d: a 12-term
// series for the fraction, then one multiply by exp(-1) per integer unit.
// ----------------------------------------------------------------------------
module imhcs_exp
    import imhcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] d,
    output logic               done,
    output logic [16:0]        value
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_DIV,
        E_ACC,
        E_SCALE,
        E_DONE
    } exp_state_t;

    exp_state_t         state_reg;
    logic [15:0]        f_reg;
    logic [3:0]         n_reg;
    logic [3:0]         k_reg;
    logic [2:0]         div_cnt_reg;
    logic [32:0]        term_reg;
    logic signed [34:0] sum_reg;
    logic [33:0]        a_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [3:0]         rem_reg;

    logic [32:0]        x;
    logic [48:0]        term_prod;
    logic [65:0]        scale_prod;
    logic [DIV_W-1:0]   dvd_next;
    logic [DIV_W-1:0]   quo_next;
    logic [3:0]         rem_next;
    logic [32:0]        new_term;
    logic signed [34:0] sum_next;
    logic [34:0]        rnd;

    assign x          = 33'(-d);
    assign term_prod  = term_reg * f_reg;
    assign scale_prod = a_reg * EXP_NEG1_Q32;
    assign new_term   = quo_reg[32:0];

    // Long division by the small term index, a few quotient bits per cycle.
    always_comb begin
        logic [4:0] t;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int j = 0; j < DIV_BITS; j++) begin
            t        = {rem_next, dvd_next[DIV_W-1]};
            dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, k_reg}) begin
                t        = t - {1'b0, k_reg};
                quo_next = {quo_next[DIV_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
            end
            rem_next = t[3:0];
        end
    end

    // Odd terms subtract, even terms add; the partial sum never goes below zero.
    always_comb begin
        if (k_reg[0]) begin
            sum_next = sum_reg - $signed({2'b00, new_term});
        end else begin
            sum_next = sum_reg + $signed({2'b00, new_term});
        end
        if (sum_next < 0) begin
            sum_next = '0;
        end
    end

    assign rnd   = {1'b0, a_reg} + 35'd32768;
    assign value = (rnd[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : rnd[32:16];
    assign done  = state_reg == E_DONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        if (!d[32]) begin
                            a_reg     <= 34'h1_0000_0000;
                            n_reg     <= '0;
                            state_reg <= E_SCALE;
                        end else if (x[31:16] >= 16'd12) begin
                            a_reg     <= '0;
                            n_reg     <= '0;
                            state_reg <= E_SCALE;
                        end else begin
                            f_reg     <= x[15:0];
                            n_reg     <= x[19:16];
                            term_reg  <= 33'h1_0000_0000;
                            sum_reg   <= 35'sh1_0000_0000;
                            k_reg     <= 4'd1;
                            state_reg <= E_MUL;
                        end
                    end
                end
                E_MUL: begin
                    dvd_reg     <= DIV_W'(term_prod[48:16]);
                    quo_reg     <= '0;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= E_DIV;
                end
                E_DIV: begin
                    dvd_reg     <= dvd_next;
                    quo_reg     <= quo_next;
                    rem_reg     <= rem_next;
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                    if (div_cnt_reg == DIV_STEPS - 3'd1) begin
                        state_reg <= E_ACC;
                    end
                end
                E_ACC: begin
                    term_reg <= new_term;
                    sum_reg  <= sum_next;
                    if (k_reg == EXP_TERMS) begin
                        a_reg     <= sum_next[33:0];
                        state_reg <= E_SCALE;
                    end else begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= E_MUL;
                    end
                end
                E_SCALE: begin
                    if (n_reg == '0) begin
                        state_reg <= E_DONE;
                    end else begin
                        a_reg <= scale_prod[65:32];
                        n_reg <= n_reg - 4'd1;
                    end
                end
                E_DONE: begin
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/imhcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhcs_back: chain back end
// Pops queued beats, decides acceptance on a vector's first coordinate,
// updates the chain state memory and fills the output register.
// ----------------------------------------------------------------------------
module imhcs_back
    import imhcs_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  in_item_t                                   q_item,
    input  tag_t                                       q_tag,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] q_idx,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output out_item_t                                  m_payload,
    output logic                                       exp_start,
    output logic signed [32:0]                         exp_d,
    input  logic                                       exp_done,
    input  logic [16:0]                                exp_value,
    output logic                                       ram_en,
    output logic                                       ram_we,
    output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] ram_addr,
    output logic [31:0]                                ram_wdata,
    input  logic [31:0]                                ram_rdata
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXP,
        B_OUT
    } back_state_t;

    back_state_t        state_reg;
    logic               latch_reg;
    logic signed [31:0] cur_lw_reg;
    in_item_t           w_item_reg;
    logic [IDX_W-1:0]   w_idx_reg;
    logic               w_last_reg;
    logic               w_acc_reg;
    logic               m_valid_reg;
    out_item_t          m_payload_reg;

    logic needs_exp;
    logic head_go;
    logic exp_acc;
    logic out_free;
    logic out_load;

    assign needs_exp = q_tag.first && !q_item.new_chain;
    assign head_go   = (state_reg == B_IDLE) && q_valid;
    assign q_pop     = head_go;
    assign exp_start = head_go && needs_exp;
    assign exp_d     = {q_item.log_weight[31], q_item.log_weight}
                     - {cur_lw_reg[31], cur_lw_reg};
    assign exp_acc   = w_item_reg.uniform <= exp_value;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == B_OUT) && out_free;

    // Memory access: straight from the queue head, or once the exponent is in.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = q_idx;
        ram_wdata = q_item.coord_value;
        if (head_go && !needs_exp) begin
            ram_en = 1'b1;
            ram_we = q_tag.first ? 1'b1 : latch_reg;
        end else if ((state_reg == B_EXP) && exp_done) begin
            ram_en    = 1'b1;
            ram_we    = exp_acc;
            ram_addr  = w_idx_reg;
            ram_wdata = w_item_reg.coord_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            latch_reg   <= 1'b0;
            cur_lw_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        w_item_reg <= q_item;
                        w_idx_reg  <= q_idx;
                        w_last_reg <= q_tag.last;
                        if (needs_exp) begin
                            state_reg <= B_EXP;
                        end else begin
                            if (q_tag.first) begin
                                latch_reg  <= 1'b1;
                                cur_lw_reg <= q_item.log_weight;
                                w_acc_reg  <= 1'b1;
                            end else begin
                                w_acc_reg <= latch_reg;
                            end
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_EXP: begin
                    if (exp_done) begin
                        latch_reg <= exp_acc;
                        w_acc_reg <= exp_acc;
                        if (exp_acc) begin
                            cur_lw_reg <= w_item_reg.log_weight;
                        end
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_payload_reg <= '{
                            draw_value: w_acc_reg ? w_item_reg.coord_value : ram_rdata,
                            accepted:   w_acc_reg,
                            last_coord: w_last_reg
                        };
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

FILE: sv/independence_mh_chain_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// independence_mh_chain_step_core: independence Metropolis-Hastings step
// Streams candidate coordinates through an accept/reject chain and returns
// the chain state's coordinate for each one.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one candidate coordinate per beat; a vector is
// dim_in_use beats long. On a vector's first beat the block decides
// acceptance (new_chain forces it) from uniform and the log weights.
// The m_ channel returns exactly one beat per input beat, in order: the
// chain state's coordinate at that position, the accepted flag and a
// last-coordinate mark. The cfg_ channel writes dim_in_use; write it only
// when no beat is in flight. cfg_ready is always high.
// A beat that needs no exponent (any coordinate but the first, or a first
// one with new_chain) goes through the back end in order: the queue pop
// and chain-memory access, then the load of the output register once it
// is free. A first coordinate that needs exp() is popped first, and its
// memory access waits for the iterative exponent unit: 12 series terms of
// one multiply and a divide each, then one multiply by exp(-1) per unit of
// n, n being the integer part of the log weight drop (0..11); with no drop,
// or a drop of 12 or more, the series is skipped and the result is 1 or 0.
// A 2-beat queue lets the front take beats while the back works; when the
// receiver stalls, the output register holds and the queue fills before
// s_ready drops. Reset (aresetn low, synchronous) empties the pipeline,
// sets dim_in_use to 1 and clears the stored log weight and accept flag.
// ----------------------------------------------------------------------------
module independence_mh_chain_step_core
    import imhcs_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DIM_CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int Q_W   = $bits(in_item_t) + $bits(tag_t) + IDX_W;

    // Configuration register.
    logic [DIM_CFG_W-1:0] dim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            dim_reg <= cfg_wdata;
        end
    end

    // Front end to queue.
    logic             f_push;
    logic             q_in_ready;
    in_item_t         f_item;
    tag_t             f_tag;
    logic [IDX_W-1:0] f_idx;

    // Queue to back end.
    logic             q_out_valid;
    logic             q_pop;
    logic [Q_W-1:0]   q_rdata;
    in_item_t         b_item;
    tag_t             b_tag;
    logic [IDX_W-1:0] b_idx;

    // Back end to exponent unit and chain memory.
    logic               exp_start;
    logic signed [32:0] exp_d;
    logic               exp_done;
    logic [16:0]        exp_value;
    logic               ram_en;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    imhcs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .dim_cfg    (dim_reg),
        .q_push     (f_push),
        .q_in_ready (q_in_ready),
        .q_item     (f_item),
        .q_tag      (f_tag),
        .q_idx      (f_idx)
    );

    imhcs_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .in_ready  (q_in_ready),
        .wdata     ({f_item, f_tag, f_idx}),
        .pop       (q_pop),
        .out_valid (q_out_valid),
        .rdata     (q_rdata)
    );

    assign {b_item, b_tag, b_idx} = q_rdata;

    imhcs_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_out_valid),
        .q_pop     (q_pop),
        .q_item    (b_item),
        .q_tag     (b_tag),
        .q_idx     (b_idx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .exp_start (exp_start),
        .exp_d     (exp_d),
        .exp_done  (exp_done),
        .exp_value (exp_value),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    imhcs_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .d       (exp_d),
        .done    (exp_done),
        .value   (exp_value)
    );

    // Chain state: one coordinate per position of the current vector.
    imhcs_ram #(
        .DATA_W (32),
        .DEPTH  (MAX_DIM)
    ) u_chain_mem (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // The front end pushes only when the queue has room.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        f_push |-> q_in_ready)
        else $error("queue push while full");

    // The back end pops only a beat that is there.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_out_valid)
        else $error("queue pop while empty");

    // An exponent request is a single-cycle pulse; the back end then waits.
    a_start_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_start |=> !exp_start)
        else $error("exponent start repeated");

    // No beat leaves the queue while the exponent unit reports its result.
    a_mem_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_done |-> !q_pop)
        else $error("queue pop while exponent result pending");
`endif

endmodule
